// ===== hdl/pvd_pkg.sv =====
// Shared constants and decode helpers for the prefix varint decoder.
// Depends on nothing; used by prefix_varint_decoder.
package pvd_pkg;

  localparam int unsigned ValueWidth = 64;
  localparam int unsigned ByteWidth  = 8;
  localparam int unsigned CountWidth = 4;
  // A header byte with all ones announces a raw value in the following bytes.
  localparam logic [CountWidth-1:0] RawCount = 4'd8;

  typedef logic [ValueWidth-1:0] value_t;
  typedef logic [CountWidth-1:0] count_t;

  // Number of trailing ones in a header byte, 0 to 8.
  function automatic count_t trailing_ones(input logic [ByteWidth-1:0] b);
    count_t n;
    logic   run;
    n   = '0;
    run = 1'b1;
    for (int i = 0; i < ByteWidth; i++) begin
      run = run & b[i];
      if (run) begin
        n = n + count_t'(1);
      end
    end
    return n;
  endfunction

  // Builds the value from the header, the gathered bytes and the last byte.
  function automatic value_t assemble(input logic [ByteWidth-1:0] first,
                                      input count_t n,
                                      input value_t acc,
                                      input logic [ByteWidth-1:0] last);
    value_t     v;
    logic [2:0] n3;
    logic [2:0] up;
    logic [3:0] down;
    logic [5:0] sign_pos;
    n3       = n[2:0];
    up       = 3'd7 - n3;
    down     = {1'b0, n3} + 4'd1;
    sign_pos = ({3'b000, n3} + 6'd1) * 6'd7;
    v        = (acc << up) | value_t'(first >> down);
    if (last[ByteWidth-1]) begin
      v = v | (~value_t'(0) << sign_pos);
    end
    if (n >= RawCount) begin
      v = acc;
    end
    return v;
  endfunction

endpackage

// ===== hdl/prefix_varint_decoder.sv =====
// Top level of the prefix varint decoder: byte state tracking and result register.
// Depends on pvd_pkg for types, constants and the decode helpers.
//
// Usage: encoded bytes enter on the in_ channel, one per transaction, with
// buffer_end marking the last byte of the buffer. Each completed encoding, or
// a buffer that ends inside an encoding, yields one transaction on the out_
// channel; other bytes yield none. A transaction is taken at a rising edge
// with valid high and stall low.
// A result appears in the cycle after the byte that completes it is taken.
// Throughput: one byte per cycle while in_stall is low; a byte's decode is a
// single registered pass: trailing-ones count, byte placement and value assembly.
// Reset (rst, synchronous) returns the decoder to the start of an encoding
// and empties the result register.
// When the receiver stalls, the result register holds; in_stall rises only
// while a held result is still waiting, so bytes keep flowing otherwise.
module prefix_varint_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        buffer_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] decoded_value,
  output logic [3:0]  consumed_bytes,
  output logic        truncated
);

  logic             in_progress;
  pvd_pkg::count_t  bytes_remaining;
  pvd_pkg::count_t  extra_byte_count;
  logic [7:0]       header_byte;
  pvd_pkg::value_t  accumulator;

  logic             in_progress_next;
  pvd_pkg::count_t  bytes_remaining_next;
  pvd_pkg::count_t  extra_byte_count_next;
  logic [7:0]       header_byte_next;
  pvd_pkg::value_t  accumulator_next;

  logic             take;
  logic             fire;
  pvd_pkg::value_t  res_value;
  pvd_pkg::count_t  res_consumed;
  logic             res_trunc;

  pvd_pkg::count_t  head_n;
  logic [2:0]       idx;
  pvd_pkg::value_t  acc_upd;
  pvd_pkg::count_t  rem_dec;

  assign in_stall = out_valid & out_stall;
  assign take     = in_valid & ~in_stall;

  assign head_n  = pvd_pkg::trailing_ones(data_byte);
  assign idx     = 3'(extra_byte_count - bytes_remaining);
  assign acc_upd = accumulator | (pvd_pkg::value_t'(data_byte) << {idx, 3'b000});
  assign rem_dec = (bytes_remaining != '0) ? bytes_remaining - 4'd1 : bytes_remaining;

  always_comb begin
    in_progress_next      = in_progress;
    bytes_remaining_next  = bytes_remaining;
    extra_byte_count_next = extra_byte_count;
    header_byte_next      = header_byte;
    accumulator_next      = accumulator;
    fire                  = 1'b0;
    res_value             = '0;
    res_consumed          = '0;
    res_trunc             = 1'b0;
    if (!in_progress) begin
      if (head_n == '0) begin
        fire         = 1'b1;
        res_value    = pvd_pkg::assemble(data_byte, '0, '0, data_byte);
        res_consumed = 4'd1;
      end else if (buffer_end) begin
        fire      = 1'b1;
        res_trunc = 1'b1;
      end else begin
        in_progress_next      = 1'b1;
        header_byte_next      = data_byte;
        extra_byte_count_next = head_n;
        bytes_remaining_next  = head_n;
        accumulator_next      = '0;
      end
    end else begin
      accumulator_next     = acc_upd;
      bytes_remaining_next = rem_dec;
      if (rem_dec == '0) begin
        fire         = 1'b1;
        res_value    = pvd_pkg::assemble(header_byte, extra_byte_count, acc_upd, data_byte);
        res_consumed = extra_byte_count + 4'd1;
      end else if (buffer_end) begin
        fire      = 1'b1;
        res_trunc = 1'b1;
      end
      if (fire) begin
        in_progress_next      = 1'b0;
        bytes_remaining_next  = '0;
        extra_byte_count_next = '0;
        header_byte_next      = '0;
        accumulator_next      = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_progress      <= 1'b0;
      bytes_remaining  <= '0;
      extra_byte_count <= '0;
      header_byte      <= '0;
      accumulator      <= '0;
    end else if (take) begin
      in_progress      <= in_progress_next;
      bytes_remaining  <= bytes_remaining_next;
      extra_byte_count <= extra_byte_count_next;
      header_byte      <= header_byte_next;
      accumulator      <= accumulator_next;
    end
  end

  // The result register loads only when it is empty or being drained.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take && fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && fire) begin
      decoded_value  <= res_value;
      consumed_bytes <= res_consumed;
      truncated      <= res_trunc;
    end
  end

endmodule
